[rtl/h264_rtp_fua_packetizer_unit_defines.svh]
// Assertion helpers for the packetizer output stage (h264fua_back).
// Both expect signals named clock and reset in the enclosing module.
`ifndef H264_RTP_FUA_PACKETIZER_UNIT_DEFINES_SVH
`define H264_RTP_FUA_PACKETIZER_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define H264FUA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define H264FUA_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/h264fua_pkg.sv]
`default_nettype none

package h264fua_pkg;

   localparam int MP_W = 14;
   localparam logic [MP_W-1:0] MP_RESET = 14'd1488;

   localparam logic [7:0] FU_A_TYPE = 8'd28;
   localparam logic [7:0] NRI_MASK  = 8'h60;
   localparam logic [7:0] S_BIT     = 8'h80;
   localparam logic [7:0] E_BIT     = 8'h40;
   localparam logic [7:0] TYPE_MASK = 8'h1f;

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   // One queue entry: either a single output word, or the three words that
   // open a fragment (indicator, FU header, first data byte).
   typedef struct packed {
      logic       frag;
      logic [7:0] ind;
      logic [7:0] fuh;
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       mark;
   } entry_type;

endpackage

`default_nettype wire

[rtl/h264fua_front.sv]
`default_nettype none

module h264fua_front #(
   parameter int LEN_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          csr_valid,
   input  wire [h264fua_pkg::MP_W-1:0]  csr_data,
   input  wire                          take,
   input  wire [7:0]                    data_byte,
   input  wire                          nal_start,
   input  wire [LEN_BITS-1:0]           nal_length,
   input  wire                          unit_ends_frame,
   output logic                         push,
   output h264fua_pkg::entry_type       entry
);

   localparam int MPW = h264fua_pkg::MP_W;
   localparam int CW  = ((LEN_BITS > MPW) ? LEN_BITS : MPW) + 1;

   logic [MPW-1:0]      mp_ff, mp_in;
   logic                frag_mode_ff, frag_mode_in;
   logic [7:0]          hdr_ff, hdr_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic [MPW-1:0]      room_ff, room_in;
   logic                first_frag_ff, first_frag_in;
   logic                endp_ff, endp_in;

   logic                fits;
   logic [MPW-1:0]      cap;
   logic [MPW-1:0]      chunk;
   logic                chunk_all;
   logic                room_eq_left;

   always_comb begin
      fits = (CW'(nal_length) + CW'(1)) <= CW'(mp_ff);
      cap = (mp_ff > MPW'(2)) ? (mp_ff - MPW'(2)) : MPW'(1);
      chunk = (CW'(left_ff) < CW'(cap)) ? MPW'(left_ff) : cap;
      chunk_all = CW'(chunk) == CW'(left_ff);
      room_eq_left = CW'(room_ff) == CW'(left_ff);
   end

   always_comb begin
      mp_in = csr_valid ? csr_data : mp_ff;
      frag_mode_in = frag_mode_ff;
      hdr_in = hdr_ff;
      left_in = left_ff;
      room_in = room_ff;
      first_frag_in = first_frag_ff;
      endp_in = endp_ff;
      push = 1'b0;
      entry = '0;
      entry.data = data_byte;
      if (take) begin
         if (nal_start) begin
            hdr_in = data_byte;
            endp_in = unit_ends_frame;
            left_in = nal_length;
            first_frag_in = 1'b1;
            room_in = '0;
            frag_mode_in = !fits;
            if (fits) begin
               push = 1'b1;
               entry.first = 1'b1;
               entry.last = (nal_length == '0);
               entry.mark = unit_ends_frame;
            end
         end else if (left_ff != '0) begin
            push = 1'b1;
            left_in = left_ff - LEN_BITS'(1);
            if (!frag_mode_ff) begin
               entry.last = (left_ff == LEN_BITS'(1));
               entry.mark = endp_ff;
            end else if (room_ff == '0) begin
               // First data byte of a fragment: prepend indicator and FU header.
               entry.frag = 1'b1;
               entry.ind = (hdr_ff & h264fua_pkg::NRI_MASK) | h264fua_pkg::FU_A_TYPE;
               entry.fuh = (first_frag_ff ? h264fua_pkg::S_BIT : 8'h00)
                         | (chunk_all ? h264fua_pkg::E_BIT : 8'h00)
                         | (hdr_ff & h264fua_pkg::TYPE_MASK);
               entry.last = (chunk == MPW'(1));
               entry.mark = endp_ff & chunk_all;
               room_in = chunk - MPW'(1);
               first_frag_in = 1'b0;
            end else begin
               entry.last = (room_ff == MPW'(1));
               entry.mark = endp_ff & room_eq_left;
               room_in = room_ff - MPW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff <= h264fua_pkg::MP_RESET;
         frag_mode_ff <= 1'b0;
         hdr_ff <= '0;
         left_ff <= '0;
         room_ff <= '0;
         first_frag_ff <= 1'b1;
         endp_ff <= 1'b0;
      end else begin
         mp_ff <= mp_in;
         frag_mode_ff <= frag_mode_in;
         hdr_ff <= hdr_in;
         left_ff <= left_in;
         room_ff <= room_in;
         first_frag_ff <= first_frag_in;
         endp_ff <= endp_in;
      end
   end

endmodule

`default_nettype wire

[rtl/h264fua_queue.sv]
`default_nettype none

module h264fua_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire h264fua_pkg::entry_type  push_entry,
   output logic                         full,
   input  wire                          pop,
   output h264fua_pkg::entry_type       head,
   output logic                         head_valid
);

   localparam int QAW = h264fua_pkg::QAW;

   h264fua_pkg::entry_type mem_ff [h264fua_pkg::QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   always_comb begin
      full = (count_ff == (QAW+1)'(h264fua_pkg::QDEPTH));
      head_valid = (count_ff != '0);
      head = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/h264fua_back.sv]
`default_nettype none
`include "h264_rtp_fua_packetizer_unit_defines.svh"

module h264fua_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          q_valid,
   input  wire h264fua_pkg::entry_type  q_head,
   output logic                         q_pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tlast,
   output logic [1:0]                   rsp_tuser
);

   typedef enum logic [1:0] {PH_IND, PH_FUH, PH_DATA} phase_type;

   h264fua_pkg::entry_type cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   phase_type              phase_ff, phase_in;

   logic fire;
   logic done;
   logic load;

   always_comb begin
      fire = cur_valid_ff && rsp_tready;
      done = !cur_ff.frag || (phase_ff == PH_DATA);
      load = !cur_valid_ff || (fire && done);
      q_pop = load && q_valid;

      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in = phase_ff;
      if (load) begin
         cur_in = q_head;
         cur_valid_in = q_valid;
         phase_in = PH_IND;
      end else if (fire) begin
         case (phase_ff)
            PH_IND:  phase_in = PH_FUH;
            PH_FUH:  phase_in = PH_DATA;
            default: phase_in = PH_DATA;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff <= PH_IND;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff <= phase_in;
      end
   end

   // tuser bit 0 is packet_first, bit 1 is marker.
   always_comb begin
      rsp_tvalid = cur_valid_ff;
      rsp_tdata = cur_ff.data;
      rsp_tlast = cur_ff.last;
      rsp_tuser = {cur_ff.mark, cur_ff.first};
      if (cur_ff.frag) begin
         case (phase_ff)
            PH_IND: begin
               rsp_tdata = cur_ff.ind;
               rsp_tlast = 1'b0;
               rsp_tuser = {cur_ff.mark, 1'b1};
            end
            PH_FUH: begin
               rsp_tdata = cur_ff.fuh;
               rsp_tlast = 1'b0;
               rsp_tuser = {cur_ff.mark, 1'b0};
            end
            default: begin
               rsp_tdata = cur_ff.data;
               rsp_tlast = cur_ff.last;
               rsp_tuser = {cur_ff.mark, 1'b0};
            end
         endcase
      end
   end

   `H264FUA_ASSERT(a_phase_only_frag, (cur_valid_ff && phase_ff != PH_IND) |-> cur_ff.frag, "phase advanced on a single word entry")
   `H264FUA_ASSERT(a_ind_to_fuh, (cur_valid_ff && rsp_tready && cur_ff.frag && phase_ff == PH_IND) |=> (cur_valid_ff && phase_ff == PH_FUH), "FU header did not follow indicator")
   `H264FUA_ASSERT(a_fuh_to_data, (cur_valid_ff && rsp_tready && cur_ff.frag && phase_ff == PH_FUH) |=> (cur_valid_ff && phase_ff == PH_DATA && cur_ff.frag), "data byte did not follow FU header")

endmodule

`default_nettype wire

[rtl/h264_rtp_fua_packetizer_unit.sv]
// H.264 RTP payload packetizer with FU-A fragmentation.
// req_ carries NAL bytes without start codes, one word per byte. A word with
// req_tuser high is a NAL header and carries the payload length and, on
// req_tlast, the end-of-access-unit flag. rsp_ carries RTP payload bytes:
// rsp_tuser[0] marks the first byte of a payload, rsp_tlast the last, and
// rsp_tuser[1] is the RTP marker, set on every byte of the last packet of an
// access unit. csr_ writes the maximum payload size (reset value 1488).
// An accepted byte passes through the queue into the output stage register.
// Throughput is one byte per cycle while the queue has room; the first data
// byte of each fragment yields three words (FU indicator, FU header, data)
// that the output stage sends in turn, so the input slows only there.
// A four-entry queue separates the classifying front end from the output
// stage; req_tready drops only while that queue is full, so a stalled
// receiver backs up into the input once four entries wait behind the one
// held in the output stage.
// Reset clears all packetizer state and empties the queue; configuration is
// to be written only while the block is idle.
`default_nettype none

module h264_rtp_fua_packetizer_unit #(
   parameter int LEN_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [23:0]  req_tdata,   // [7:0] data_byte, [23:8] nal_length
   input  wire         req_tuser,   // [0] nal_start
   input  wire         req_tlast,   // unit_ends_frame
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [0] packet_first, [1] marker
   output logic        rsp_tlast,   // packet_last
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [13:0]  csr_data
);

   logic                   q_full;
   logic                   push;
   h264fua_pkg::entry_type push_entry;
   logic                   pop;
   h264fua_pkg::entry_type head;
   logic                   head_valid;
   logic                   take;

   assign req_tready = !q_full;
   assign csr_ready = 1'b1;
   assign take = req_tvalid && req_tready;

   h264fua_front #(
      .LEN_BITS(LEN_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .take(take),
      .data_byte(req_tdata[7:0]),
      .nal_start(req_tuser),
      .nal_length(LEN_BITS'(req_tdata[23:8])),
      .unit_ends_frame(req_tlast),
      .push(push),
      .entry(push_entry)
   );

   h264fua_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .full(q_full),
      .pop(pop),
      .head(head),
      .head_valid(head_valid)
   );

   h264fua_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(head_valid),
      .q_head(head),
      .q_pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule

`default_nettype wire
